>>> design/obub_pkg.sv
`default_nettype none
package obub_pkg;

  localparam int CoordW = 17;
  localparam int DiffW  = 18;
  localparam int BoxW   = 18;
  localparam int SizeW  = 16;
  localparam int HalfW  = 15;
  localparam int CfgIdxW = 2;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_CLIP_ENABLE = 2'd0,
    CFG_PAGE_WIDTH  = 2'd1,
    CFG_PAGE_HEIGHT = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic             clip_enable;
    logic [SizeW-1:0] page_width;
    logic [SizeW-1:0] page_height;
  } cfg_t;

  // one classified zone request, as queued between front and back
  typedef struct packed {
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
    logic signed [DiffW-1:0]  dx;
    logic signed [DiffW-1:0]  dy;
    logic [HalfW-1:0]         half_height;
    logic [SizeW-1:0]         page_number;
    logic                     last_zone;
    logic                     zero_len;
  } zone_t;

  // queue status seen by the back end
  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

endpackage
`default_nettype wire

>>> design/obub_front.sv
`default_nettype none
module obub_front
  import obub_pkg::*;
(
  input  wire logic signed [CoordW-1:0] start_x_i,
  input  wire logic signed [CoordW-1:0] start_y_i,
  input  wire logic signed [CoordW-1:0] end_x_i,
  input  wire logic signed [CoordW-1:0] end_y_i,
  input  wire logic [SizeW-1:0]         zone_height_i,
  input  wire logic [SizeW-1:0]         page_number_i,
  input  wire logic                     last_zone_i,
  output zone_t                         zone_o
);

  logic signed [DiffW-1:0] dx, dy;

  // direction vector and degenerate line check
  always_comb begin
    dx = DiffW'(end_x_i) - DiffW'(start_x_i);
    dy = DiffW'(end_y_i) - DiffW'(start_y_i);
    zone_o.start_x     = start_x_i;
    zone_o.start_y     = start_y_i;
    zone_o.end_x       = end_x_i;
    zone_o.end_y       = end_y_i;
    zone_o.dx          = dx;
    zone_o.dy          = dy;
    zone_o.half_height = zone_height_i[SizeW-1:1];
    zone_o.page_number = page_number_i;
    zone_o.last_zone   = last_zone_i;
    zone_o.zero_len    = (dx == '0) && (dy == '0);
  end

endmodule
`default_nettype wire

>>> design/obub_queue.sv
`default_nettype none
module obub_queue
  import obub_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_i,
  input  zone_t     wr_data_i,
  input  wire logic rd_i,
  output zone_t     rd_data_o,
  output qstat_t    stat_o
);

  zone_t       mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;

  assign stat_o.empty = (count_q == 2'd0);
  assign stat_o.full  = (count_q == 2'd2);
  assign rd_data_o    = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (wr_i) wr_ptr_q <= ~wr_ptr_q;
      if (rd_i) rd_ptr_q <= ~rd_ptr_q;
      if (wr_i && !rd_i)      count_q <= count_q + 2'd1;
      else if (rd_i && !wr_i) count_q <= count_q - 2'd1;
    end
  end

endmodule
`default_nettype wire

>>> design/obub_back.sv
`default_nettype none
module obub_back
  import obub_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  cfg_t      cfg_i,
  input  qstat_t    qstat_i,
  input  zone_t     zone_i,
  output logic      q_rd_o,
  output logic      empty,
  input  wire logic pop,
  output logic signed [BoxW-1:0] box_left_o,
  output logic signed [BoxW-1:0] box_top_o,
  output logic signed [BoxW-1:0] box_right_o,
  output logic signed [BoxW-1:0] box_bottom_o,
  output logic                   status_o
);

  localparam int F   = FRAC_BITS;
  localparam int RW  = 2 * F + 39;
  localparam int QW  = F + 1;
  localparam int SW  = F + 2;
  localparam int OW  = F + 17;
  localparam int NW  = F + 20;
  localparam int CW  = $clog2(F + 1);
  localparam logic [CW-1:0] CntInit = CW'(F);
  localparam logic [NW-1:0] RoundC  = NW'((64'd1 << F) - 64'd1);
  localparam logic signed [SW-1:0] OneQ = SW'(64'd1 << F);

  typedef enum logic [2:0] {
    S_IDLE, S_SQ, S_INIT, S_ITER, S_MUL, S_FOLD
  } state_e;

  state_e state_q;
  zone_t  zone_q;
  logic [35:0]   sqx_q, sqy_q;
  logic [RW-1:0] a_q, rx_q, ry_q, bx_q, by_q;
  logic [QW-1:0] qx_q, qy_q;
  logic [CW-1:0] cnt_q;
  logic signed [OW-1:0] ox_q, oy_q;

  logic run_started_q, mismatch_q;
  logic [SizeW-1:0] run_page_q;
  logic signed [BoxW-1:0] ul_q, ut_q, ur_q, ub_q;
  logic out_valid_q;

  // one restoring step per lane
  logic [RW-1:0] tx, ty, rx_n, ry_n, bx_n, by_n;
  logic          accx, accy;
  always_comb begin
    tx   = a_q + bx_q;
    ty   = a_q + by_q;
    accx = (tx <= rx_q);
    accy = (ty <= ry_q);
    rx_n = accx ? rx_q - tx : rx_q;
    ry_n = accy ? ry_q - ty : ry_q;
    bx_n = accx ? bx_q + (a_q << 1) : bx_q;
    by_n = accy ? by_q + (a_q << 1) : by_q;
  end

  // signed unit components
  logic signed [SW-1:0] sn, cs;
  always_comb begin
    if (zone_q.zero_len) begin
      sn = '0;
      cs = OneQ;
    end else begin
      sn = zone_q.dy[DiffW-1] ? -$signed({1'b0, qy_q}) : $signed({1'b0, qy_q});
      cs = zone_q.dx[DiffW-1] ? -$signed({1'b0, qx_q}) : $signed({1'b0, qx_q});
    end
  end

  function automatic logic signed [BoxW-1:0] corner_f(
    input logic signed [CoordW-1:0] c,
    input logic signed [OW-1:0]     off,
    input logic                     neg
  );
    logic signed [NW-1:0] o, n, adj;
    begin
      o   = NW'(off);
      n   = (NW'(c) <<< F) + (neg ? -o : o);
      adj = n[NW-1] ? n + $signed(RoundC) : n;
      corner_f = BoxW'(adj >>> F);
    end
  endfunction

  function automatic logic signed [BoxW-1:0] min2(input logic signed [BoxW-1:0] a,
                                                  input logic signed [BoxW-1:0] b);
    min2 = (b < a) ? b : a;
  endfunction

  function automatic logic signed [BoxW-1:0] max2(input logic signed [BoxW-1:0] a,
                                                  input logic signed [BoxW-1:0] b);
    max2 = (b > a) ? b : a;
  endfunction

  // corners, zone bounds, folded union and clipped result
  logic signed [BoxW-1:0] x0, x1, x2, x3, y0, y1, y2, y3;
  logic signed [BoxW-1:0] zl, zt, zr, zb, nl, nt, nr, nb, cl, ct, cr, cb;
  logic                   n_mis, emit_ok, fold_go;
  always_comb begin
    x0 = corner_f(zone_q.start_x, ox_q, 1'b1);
    y0 = corner_f(zone_q.start_y, oy_q, 1'b0);
    x1 = corner_f(zone_q.end_x, ox_q, 1'b1);
    y1 = corner_f(zone_q.end_y, oy_q, 1'b0);
    x2 = corner_f(zone_q.end_x, ox_q, 1'b0);
    y2 = corner_f(zone_q.end_y, oy_q, 1'b1);
    x3 = corner_f(zone_q.start_x, ox_q, 1'b0);
    y3 = corner_f(zone_q.start_y, oy_q, 1'b1);
    zl = min2(min2(x0, x1), min2(x2, x3));
    zr = max2(max2(x0, x1), max2(x2, x3));
    zt = min2(min2(y0, y1), min2(y2, y3));
    zb = max2(max2(y0, y1), max2(y2, y3));
    if (!run_started_q) begin
      nl = zl; nt = zt; nr = zr; nb = zb;
      n_mis = 1'b0;
    end else begin
      nl = min2(ul_q, zl); nt = min2(ut_q, zt);
      nr = max2(ur_q, zr); nb = max2(ub_q, zb);
      n_mis = mismatch_q || (zone_q.page_number != run_page_q);
    end
    cl = nl; ct = nt; cr = nr; cb = nb;
    if (cfg_i.clip_enable) begin
      if (ct < 0) ct = '0;
      if (cl < 0) cl = '0;
      if (cb > $signed({2'b00, cfg_i.page_height})) cb = $signed({2'b00, cfg_i.page_height});
      if (cr > $signed({2'b00, cfg_i.page_width}))  cr = $signed({2'b00, cfg_i.page_width});
    end
    if (n_mis) begin
      cl = '0; ct = '0; cr = '0; cb = '0;
    end
    emit_ok = !out_valid_q || pop;
    fold_go = (state_q == S_FOLD) && (!zone_q.last_zone || emit_ok);
  end

  assign q_rd_o = (state_q == S_IDLE) && !qstat_i.empty;
  assign empty  = !out_valid_q;

  // payload and datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: if (q_rd_o) zone_q <= zone_i;
      S_SQ: begin
        sqx_q <= 36'($signed(zone_q.dx) * $signed(zone_q.dx));
        sqy_q <= 36'($signed(zone_q.dy) * $signed(zone_q.dy));
      end
      S_INIT: begin
        a_q  <= RW'({1'b0, sqx_q} + {1'b0, sqy_q}) << (2 * F);
        rx_q <= RW'(sqx_q) << (2 * F);
        ry_q <= RW'(sqy_q) << (2 * F);
        bx_q <= '0;
        by_q <= '0;
        qx_q <= '0;
        qy_q <= '0;
      end
      S_ITER: begin
        rx_q <= rx_n;
        ry_q <= ry_n;
        bx_q <= bx_n >> 1;
        by_q <= by_n >> 1;
        a_q  <= a_q >> 2;
        qx_q <= {qx_q[QW-2:0], accx};
        qy_q <= {qy_q[QW-2:0], accy};
      end
      S_MUL: begin
        ox_q <= OW'($signed({1'b0, zone_q.half_height}) * sn);
        oy_q <= OW'($signed({1'b0, zone_q.half_height}) * cs);
      end
      S_FOLD: begin
        if (fold_go && zone_q.last_zone) begin
          box_left_o   <= cl;
          box_top_o    <= ct;
          box_right_o  <= cr;
          box_bottom_o <= cb;
          status_o     <= n_mis;
        end
      end
      default: ;
    endcase
  end

  // sequencer, run state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cnt_q         <= '0;
      run_started_q <= 1'b0;
      mismatch_q    <= 1'b0;
      run_page_q    <= '0;
      ul_q          <= '0;
      ut_q          <= '0;
      ur_q          <= '0;
      ub_q          <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (fold_go && zone_q.last_zone) out_valid_q <= 1'b1;
      else if (pop && out_valid_q)     out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (q_rd_o) state_q <= S_SQ;
        S_SQ:   state_q <= zone_q.zero_len ? S_MUL : S_INIT;
        S_INIT: begin
          cnt_q   <= CntInit;
          state_q <= S_ITER;
        end
        S_ITER: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) state_q <= S_MUL;
        end
        S_MUL:  state_q <= S_FOLD;
        S_FOLD: begin
          if (fold_go) begin
            state_q <= S_IDLE;
            if (zone_q.last_zone) begin
              run_started_q <= 1'b0;
              mismatch_q    <= 1'b0;
              run_page_q    <= '0;
              ul_q <= '0; ut_q <= '0; ur_q <= '0; ub_q <= '0;
            end else begin
              if (!run_started_q) run_page_q <= zone_q.page_number;
              run_started_q <= 1'b1;
              mismatch_q    <= n_mis;
              ul_q <= nl; ut_q <= nt; ur_q <= nr; ub_q <= nb;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a final zone with a free result slot always produces a result
  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FOLD && zone_q.last_zone && !out_valid_q) |=> out_valid_q)
    else $error("last zone did not produce a result");
  // mixed-page result carries an all-zero box
  a_mis_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_o) |-> (box_left_o == '0 && box_top_o == '0 &&
                                   box_right_o == '0 && box_bottom_o == '0))
    else $error("mismatch result with nonzero box");
  // iteration counter stays within the quotient width
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ITER) |-> (cnt_q <= CntInit))
    else $error("iteration counter out of range");
  // queue is read only when it holds a request
  a_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_rd_o |-> !qstat_i.empty)
    else $error("read from empty queue");
`endif

endmodule
`default_nettype wire

>>> design/oriented_box_union_bounds.sv
// Oriented box union bounds.
// Input channel: a zone request (centre line, height, page, last flag) is taken
// on a clock edge with push high and full low. A two-entry queue sits behind
// the input, so requests are taken while the back end is busy.
// Result channel: while empty is low the union box and status are on the
// result ports; they are taken on an edge with pop high. One result is given
// per run, on the zone marked last.
// Back end: it works on one zone at a time, in the steps square, init,
// iterate, multiply and fold, with a two-lane restoring unit that resolves one bit
// of sine and cosine per cycle; a zero-length zone skips init and iterate. An
// idle back end reads the queue as soon as it holds a request.
// A stalled receiver holds the result register; the back end then waits on
// the next last zone only, and the queue fills and raises full.
// Reset clears the run, the queue and the result; registers return to clip off
// and page size 65535. Configuration writes take effect at once, no wait.
`default_nettype none
module oriented_box_union_bounds
  import obub_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push,
  output logic      full,
  input  wire logic signed [CoordW-1:0] start_x_i,
  input  wire logic signed [CoordW-1:0] start_y_i,
  input  wire logic signed [CoordW-1:0] end_x_i,
  input  wire logic signed [CoordW-1:0] end_y_i,
  input  wire logic [SizeW-1:0]         zone_height_i,
  input  wire logic [SizeW-1:0]         page_number_i,
  input  wire logic                     last_zone_i,
  output logic      empty,
  input  wire logic pop,
  output logic signed [BoxW-1:0] box_left_o,
  output logic signed [BoxW-1:0] box_top_o,
  output logic signed [BoxW-1:0] box_right_o,
  output logic signed [BoxW-1:0] box_bottom_o,
  output logic                   status_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [SizeW-1:0]   cfg_data_i
);

  cfg_t   cfg_q;
  zone_t  zone_in, zone_head;
  qstat_t qstat;
  logic   q_rd;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clip_enable <= 1'b0;
      cfg_q.page_width  <= '1;
      cfg_q.page_height <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_CLIP_ENABLE: cfg_q.clip_enable <= cfg_data_i[0];
        CFG_PAGE_WIDTH:  cfg_q.page_width  <= cfg_data_i;
        CFG_PAGE_HEIGHT: cfg_q.page_height <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign full = qstat.full;

  obub_front u_front (
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .zone_height_i (zone_height_i),
    .page_number_i (page_number_i),
    .last_zone_i   (last_zone_i),
    .zone_o        (zone_in)
  );

  obub_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (push && !qstat.full),
    .wr_data_i (zone_in),
    .rd_i      (q_rd),
    .rd_data_o (zone_head),
    .stat_o    (qstat)
  );

  obub_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .qstat_i      (qstat),
    .zone_i       (zone_head),
    .q_rd_o       (q_rd),
    .empty        (empty),
    .pop          (pop),
    .box_left_o   (box_left_o),
    .box_top_o    (box_top_o),
    .box_right_o  (box_right_o),
    .box_bottom_o (box_bottom_o),
    .status_o     (status_o)
  );

endmodule
`default_nettype wire

>>> tb/tb_oriented_box_union_bounds.sv
`default_nettype none
module tb_oriented_box_union_bounds;
  import obub_pkg::*;

  localparam int FracBits = 16;
  localparam int SettleCycles = 40;

  typedef struct packed {
    logic signed [BoxW-1:0] left;
    logic signed [BoxW-1:0] top;
    logic signed [BoxW-1:0] right;
    logic signed [BoxW-1:0] bottom;
    logic                   status;
  } union_box_t;

  logic clk_i;
  logic rst_ni;
  logic push;
  logic full;
  logic signed [CoordW-1:0] start_x_i;
  logic signed [CoordW-1:0] start_y_i;
  logic signed [CoordW-1:0] end_x_i;
  logic signed [CoordW-1:0] end_y_i;
  logic [SizeW-1:0] zone_height_i;
  logic [SizeW-1:0] page_number_i;
  logic last_zone_i;
  logic empty;
  logic pop;
  logic signed [BoxW-1:0] box_left_o;
  logic signed [BoxW-1:0] box_top_o;
  logic signed [BoxW-1:0] box_right_o;
  logic signed [BoxW-1:0] box_bottom_o;
  logic status_o;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [SizeW-1:0] cfg_data_i;

  // mirrored configuration
  logic mdl_clip;
  logic [SizeW-1:0] mdl_page_w;
  logic [SizeW-1:0] mdl_page_h;

  // mirrored run state
  logic mdl_started;
  logic [SizeW-1:0] mdl_run_page;
  longint mdl_left, mdl_top, mdl_right, mdl_bottom;
  logic mdl_mismatch;

  union_box_t pending_boxes[$];
  int errors;
  int burst_left;
  int rx_mode;

  oriented_box_union_bounds #(.FRAC_BITS(FracBits)) i_dut (
    .clk_i, .rst_ni, .push, .full,
    .start_x_i, .start_y_i, .end_x_i, .end_y_i,
    .zone_height_i, .page_number_i, .last_zone_i,
    .empty, .pop,
    .box_left_o, .box_top_o, .box_right_o, .box_bottom_o, .status_o,
    .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  // clock
  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // limit on run length
  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

  // floor(|d| * 2^frac / sqrt(s2)) with sign restored
  function automatic longint unit_part(longint d, longint s2);
    logic [127:0] target;
    logic [127:0] prod;
    logic [127:0] cc;
    longint ad;
    longint q;
    longint c;
    ad = (d < 0) ? -d : d;
    q = 0;
    target = 128'(ad * ad) << (2 * FracBits);
    for (int b = FracBits; b >= 0; b--) begin
      c = q | (64'sd1 << b);
      cc = 128'(c * c);
      prod = cc * 128'(s2);
      if (prod <= target) q = c;
    end
    return (d < 0) ? -q : q;
  endfunction

  function automatic longint corner_coord(longint c, longint off);
    longint one;
    one = 64'sd1 << FracBits;
    return (c * one + off) / one;
  endfunction

  // fold one accepted zone into the run, queue a box on the last zone
  task automatic fold_zone(logic signed [CoordW-1:0] sx_v, logic signed [CoordW-1:0] sy_v,
                           logic signed [CoordW-1:0] ex_v, logic signed [CoordW-1:0] ey_v,
                           logic [SizeW-1:0] hgt, logic [SizeW-1:0] pg, logic lst);
    longint sx, sy, ex, ey, dx, dy, s2, sn, cs, h2, ox, oy;
    longint xs[4];
    longint ys[4];
    longint lft, top, rgt, bot;
    union_box_t box;
    sx = sx_v; sy = sy_v; ex = ex_v; ey = ey_v;
    dx = ex - sx;
    dy = ey - sy;
    s2 = dx * dx + dy * dy;
    h2 = longint'(hgt >> 1);
    if (s2 == 0) begin
      sn = 0;
      cs = 64'sd1 << FracBits;
    end else begin
      sn = unit_part(dy, s2);
      cs = unit_part(dx, s2);
    end
    ox = h2 * sn;
    oy = h2 * cs;
    xs[0] = corner_coord(sx, -ox); ys[0] = corner_coord(sy, oy);
    xs[1] = corner_coord(ex, -ox); ys[1] = corner_coord(ey, oy);
    xs[2] = corner_coord(ex, ox);  ys[2] = corner_coord(ey, -oy);
    xs[3] = corner_coord(sx, ox);  ys[3] = corner_coord(sy, -oy);
    lft = xs[0]; rgt = xs[0]; top = ys[0]; bot = ys[0];
    for (int i = 1; i < 4; i++) begin
      if (xs[i] < lft) lft = xs[i];
      if (xs[i] > rgt) rgt = xs[i];
      if (ys[i] < top) top = ys[i];
      if (ys[i] > bot) bot = ys[i];
    end
    if (!mdl_started) begin
      mdl_started = 1'b1;
      mdl_run_page = pg;
      mdl_mismatch = 1'b0;
      mdl_left = lft; mdl_top = top; mdl_right = rgt; mdl_bottom = bot;
    end else begin
      if (pg != mdl_run_page) mdl_mismatch = 1'b1;
      if (lft < mdl_left) mdl_left = lft;
      if (top < mdl_top) mdl_top = top;
      if (rgt > mdl_right) mdl_right = rgt;
      if (bot > mdl_bottom) mdl_bottom = bot;
    end
    if (lst) begin
      lft = mdl_left; top = mdl_top; rgt = mdl_right; bot = mdl_bottom;
      if (mdl_clip) begin
        if (top < 0) top = 0;
        if (lft < 0) lft = 0;
        if (bot > longint'(mdl_page_h)) bot = longint'(mdl_page_h);
        if (rgt > longint'(mdl_page_w)) rgt = longint'(mdl_page_w);
      end
      if (mdl_mismatch) begin
        lft = 0; top = 0; rgt = 0; bot = 0;
      end
      box.left = lft[BoxW-1:0];
      box.top = top[BoxW-1:0];
      box.right = rgt[BoxW-1:0];
      box.bottom = bot[BoxW-1:0];
      box.status = mdl_mismatch;
      pending_boxes.push_back(box);
      mdl_started = 1'b0;
      mdl_run_page = '0;
      mdl_left = 0; mdl_top = 0; mdl_right = 0; mdl_bottom = 0;
      mdl_mismatch = 1'b0;
    end
  endtask

  // send one zone request, bursts with random gaps
  task automatic send_zone(logic signed [CoordW-1:0] sx, logic signed [CoordW-1:0] sy,
                           logic signed [CoordW-1:0] ex, logic signed [CoordW-1:0] ey,
                           logic [SizeW-1:0] hgt, logic [SizeW-1:0] pg, logic lst);
    if (burst_left == 0) begin
      push = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
    end
    start_x_i = sx; start_y_i = sy; end_x_i = ex; end_y_i = ey;
    zone_height_i = hgt; page_number_i = pg; last_zone_i = lst;
    push = 1'b1;
    do @(posedge clk_i); while (full);
    fold_zone(sx, sy, ex, ey, hgt, pg, lst);
    burst_left--;
    @(negedge clk_i);
    if (burst_left == 0) push = 1'b0;
  endtask

  // wait until every box has come, then let the back end settle
  task automatic drain;
    push = 1'b0;
    while (pending_boxes.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [SizeW-1:0] data);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_CLIP_ENABLE: mdl_clip = data[0];
      CFG_PAGE_WIDTH:  mdl_page_w = data;
      CFG_PAGE_HEIGHT: mdl_page_h = data;
      default: ;
    endcase
  endtask

  task automatic set_page(logic clip, logic [SizeW-1:0] w, logic [SizeW-1:0] h);
    write_cfg(CFG_CLIP_ENABLE, {15'd0, clip});
    write_cfg(CFG_PAGE_WIDTH, w);
    write_cfg(CFG_PAGE_HEIGHT, h);
  endtask

  // random zone, full range or near the page
  task automatic send_random_zone(logic [SizeW-1:0] pg, logic lst);
    logic signed [CoordW-1:0] sx, sy, ex, ey;
    logic [SizeW-1:0] hgt;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      sx = CoordW'($urandom); sy = CoordW'($urandom);
      ex = CoordW'($urandom); ey = CoordW'($urandom);
      hgt = SizeW'($urandom);
    end else begin
      sx = CoordW'($urandom_range(0, 3000) - 500);
      sy = CoordW'($urandom_range(0, 3000) - 500);
      ex = CoordW'($urandom_range(0, 3000) - 500);
      ey = CoordW'($urandom_range(0, 3000) - 500);
      hgt = SizeW'($urandom_range(0, 400));
      if (kind == 9) begin
        ex = sx; ey = sy;
      end else if (kind == 8) begin
        ex = sx;
      end else if (kind == 7) begin
        ey = sy;
      end
    end
    send_zone(sx, sy, ex, ey, hgt, pg, lst);
  endtask

  task automatic send_random_runs(int count);
    logic [SizeW-1:0] pg;
    int len;
    int sent;
    sent = 0;
    while (sent < count) begin
      len = $urandom_range(1, 5);
      pg = ($urandom_range(0, 1) == 0) ? SizeW'($urandom) : SizeW'($urandom_range(0, 3));
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 11) == 0)
          send_random_zone(pg ^ 16'(1 << $urandom_range(0, 15)), i == len - 1);
        else
          send_random_zone(pg, i == len - 1);
        sent++;
      end
    end
  endtask

  // corner cases: extremes, zero length, single zone, mixed pages
  task automatic test_directed;
    send_zone(17'sd0, 17'sd0, 17'sd0, 17'sd0, 16'd10, 16'd0, 1'b1);
    send_zone(17'sd100, 17'sd50, 17'sd100, 17'sd50, 16'd65535, 16'd1, 1'b1);
    send_zone(-17'sd65536, -17'sd65536, 17'sd65535, 17'sd65535, 16'd65535, 16'hffff, 1'b1);
    send_zone(17'sd65535, -17'sd65536, -17'sd65536, 17'sd65535, 16'd65534, 16'd7, 1'b1);
    send_zone(17'sd10, 17'sd10, 17'sd10, 17'sd500, 16'd21, 16'd2, 1'b1);
    send_zone(17'sd10, 17'sd10, 17'sd500, 17'sd10, 16'd0, 16'd2, 1'b1);
    send_zone(17'sd500, 17'sd10, 17'sd10, 17'sd10, 16'd1, 16'd2, 1'b1);
    send_zone(17'sd3, 17'sd4, 17'sd6, 17'sd8, 16'd100, 16'd3, 1'b0);
    send_zone(17'sd200, 17'sd300, 17'sd250, 17'sd290, 16'd40, 16'd3, 1'b0);
    send_zone(-17'sd20, 17'sd5, 17'sd40, -17'sd30, 16'd9, 16'd3, 1'b1);
    send_zone(17'sd10, 17'sd10, 17'sd90, 17'sd90, 16'd8, 16'd4, 1'b0);
    send_zone(17'sd10, 17'sd10, 17'sd90, 17'sd90, 16'd8, 16'd5, 1'b1);
    send_zone(17'sd1, 17'sd1, 17'sd2, 17'sd2, 16'd2, 16'h8000, 1'b0);
    send_zone(17'sd1, 17'sd1, 17'sd2, 17'sd2, 16'd2, 16'h8000, 1'b1);
    drain();
  endtask

  // clipping with negatives and a small page
  task automatic test_clip;
    set_page(1'b1, 16'd100, 16'd80);
    write_cfg(CFG_UNUSED, 16'hffff);
    send_zone(-17'sd50, -17'sd40, 17'sd300, 17'sd200, 16'd30, 16'd0, 1'b1);
    send_zone(-17'sd500, -17'sd400, -17'sd300, -17'sd200, 16'd10, 16'd0, 1'b1);
    send_zone(17'sd20, 17'sd20, 17'sd60, 17'sd40, 16'd10, 16'd0, 1'b1);
    drain();
    set_page(1'b1, 16'd0, 16'd0);
    send_zone(17'sd5, 17'sd5, 17'sd9, 17'sd9, 16'd4, 16'd0, 1'b1);
    send_zone(-17'sd65536, -17'sd65536, 17'sd65535, 17'sd65535, 16'd65535, 16'd0, 1'b1);
    drain();
  endtask

  // random runs over a sweep of page settings
  task automatic test_random;
    set_page(1'b0, 16'd65535, 16'd65535);
    send_random_runs(300);
    drain();
    set_page(1'b1, 16'd65535, 16'd65535);
    send_random_runs(300);
    drain();
    set_page(1'b1, 16'd0, 16'd0);
    send_random_runs(250);
    drain();
    set_page(1'b1, SizeW'($urandom_range(500, 2500)), SizeW'($urandom_range(500, 2500)));
    rx_mode = 2;
    send_random_runs(350);
    drain();
    set_page(1'b1, SizeW'($urandom), SizeW'($urandom));
    rx_mode = 0;
    send_random_runs(300);
    drain();
  endtask

  // sender holds off until every box is back
  task automatic test_pause;
    set_page(1'b0, 16'd1234, 16'd4321);
    rx_mode = 1;
    for (int k = 0; k < 4; k++) begin
      send_random_runs(110);
      drain();
    end
  endtask

  // receiver stall pattern
  always @(negedge clk_i) begin
    case (rx_mode)
      0: pop <= 1'b1;
      2: pop <= ($urandom_range(0, 9) == 0);
      default: pop <= ($urandom_range(0, 2) != 0);
    endcase
  end

  // compare each popped box with the oldest expected one
  always @(posedge clk_i) begin
    union_box_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_boxes.size() == 0) begin
        $display("%0t unexpected box: left %0d top %0d right %0d bottom %0d status %0d",
                 $time, box_left_o, box_top_o, box_right_o, box_bottom_o, status_o);
        errors++;
      end else begin
        want = pending_boxes.pop_front();
        if (box_left_o !== want.left) begin
          $display("%0t box_left expected %0d actual %0d", $time, want.left, box_left_o);
          errors++;
        end
        if (box_top_o !== want.top) begin
          $display("%0t box_top expected %0d actual %0d", $time, want.top, box_top_o);
          errors++;
        end
        if (box_right_o !== want.right) begin
          $display("%0t box_right expected %0d actual %0d", $time, want.right, box_right_o);
          errors++;
        end
        if (box_bottom_o !== want.bottom) begin
          $display("%0t box_bottom expected %0d actual %0d", $time, want.bottom,
                   box_bottom_o);
          errors++;
        end
        if (status_o !== want.status) begin
          $display("%0t status expected %0d actual %0d", $time, want.status, status_o);
          errors++;
        end
      end
    end
  end

  initial begin
    errors = 0;
    burst_left = 0;
    rx_mode = 1;
    rst_ni = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    start_x_i = '0; start_y_i = '0; end_x_i = '0; end_y_i = '0;
    zone_height_i = '0; page_number_i = '0; last_zone_i = 1'b0;
    cfg_we_i = 1'b0; cfg_index_i = CFG_CLIP_ENABLE; cfg_data_i = '0;
    mdl_clip = 1'b0; mdl_page_w = 16'hffff; mdl_page_h = 16'hffff;
    mdl_started = 1'b0; mdl_run_page = '0; mdl_mismatch = 1'b0;
    mdl_left = 0; mdl_top = 0; mdl_right = 0; mdl_bottom = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_clip();
    test_random();
    test_pause();
    drain();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
